// ----- rtl/core/fadd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fadd_pkg;

    // Default width of each input field
    localparam int IN_WIDTH_DEF = 16;

    // Result field widths, fixed by the interface
    localparam int NUM_W = 33;
    localparam int DEN_W = 32;

endpackage : fadd_pkg

`default_nettype wire

// ----- rtl/core/fraction_add_and_reduce_core.sv -----
// Equal denominators skip the cross-product multiply steps and go straight to the divider.
// The divider then runs once for each Euclid remainder step and once more for each quotient.
// A zero denominator skips the arithmetic and goes straight to the finish state.
// Throughput is one item at a time. The one shared restoring divider resolves one
// quotient bit per cycle, which sets the rate.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module fraction_add_and_reduce_core #(
    parameter int IN_WIDTH = fadd_pkg::IN_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire logic signed [IN_WIDTH-1:0]         num_a,
    input  wire logic signed [IN_WIDTH-1:0]         den_a,
    input  wire logic signed [IN_WIDTH-1:0]         num_b,
    input  wire logic signed [IN_WIDTH-1:0]         den_b,
    output      logic                               out_valid,
    input  wire logic                               out_ready,
    output      logic signed [fadd_pkg::NUM_W-1:0]  sum_num,
    output      logic signed [fadd_pkg::DEN_W-1:0]  sum_den,
    output      logic signed [fadd_pkg::NUM_W-1:0]  red_num,
    output      logic signed [fadd_pkg::DEN_W-1:0]  red_den,
    output      logic                               zero_den_error
);

    import fadd_pkg::*;

    // Exact internal width of the sum and of the product
    localparam int EW = 2 * IN_WIDTH + 1;
    localparam int PW = 2 * IN_WIDTH;
    localparam int CW = $clog2(EW + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // What the current division computes
    typedef enum logic [1:0] {
        DK_EUCLID = 2'b00,
        DK_QNUM   = 2'b01,
        DK_QDEN   = 2'b10
    } div_kind_t;

    // Control registers
    state_t          state_reg, state_next;
    div_kind_t       kind_reg, kind_next;
    logic [1:0]      mstep_reg, mstep_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers
    logic signed [IN_WIDTH-1:0] na_reg, na_next;
    logic signed [IN_WIDTH-1:0] da_reg, da_next;
    logic signed [IN_WIDTH-1:0] nb_reg, nb_next;
    logic signed [IN_WIDTH-1:0] db_reg, db_next;
    logic signed [PW-1:0]       prod_reg, prod_next;
    logic signed [EW-1:0]       sn_reg, sn_next;
    logic signed [EW-1:0]       sd_reg, sd_next;
    logic signed [EW-1:0]       a_reg, a_next;
    logic signed [EW-1:0]       b_reg, b_next;
    logic signed [EW-1:0]       rn_reg, rn_next;
    logic [EW-1:0]              q_reg, q_next;
    logic [EW-1:0]              rem_reg, rem_next;
    logic [EW-1:0]              d_reg, d_next;
    logic                       neg_q_reg, neg_q_next;
    logic                       neg_r_reg, neg_r_next;
    logic                       err_reg, err_next;

    logic signed [NUM_W-1:0]    sum_num_reg, sum_num_next;
    logic signed [DEN_W-1:0]    sum_den_reg, sum_den_next;
    logic signed [NUM_W-1:0]    red_num_reg, red_num_next;
    logic signed [DEN_W-1:0]    red_den_reg, red_den_next;
    logic                       zde_reg, zde_next;

    // Shared datapath signals
    logic signed [IN_WIDTH-1:0] mul_a;
    logic signed [IN_WIDTH-1:0] mul_b;
    logic signed [PW-1:0]       mul_p;
    logic signed [EW-1:0]       dvd;
    logic [EW:0]                trial;
    logic                       trial_ge;
    logic signed [EW-1:0]       quo_s;
    logic signed [EW-1:0]       rmd_s;
    logic signed [EW-1:0]       eq_sum;
    logic                       in_xfer;
    logic                       out_free;

    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Select operands for the shared multiplier
    always_comb
    begin
        case (mstep_reg)
            2'd0:
            begin
                mul_a = na_reg;
                mul_b = db_reg;
            end
            2'd1:
            begin
                mul_a = da_reg;
                mul_b = nb_reg;
            end
            default:
            begin
                mul_a = da_reg;
                mul_b = db_reg;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Select the dividend for the shared divider
    always_comb
    begin
        case (kind_reg)
            DK_EUCLID: dvd = a_reg;
            DK_QNUM:   dvd = sn_reg;
            DK_QDEN:   dvd = sd_reg;
            default:   dvd = a_reg;
        endcase
    end

    // One restoring step: shift in the next dividend bit, try the subtract
    assign trial    = {rem_reg, q_reg[EW-1]};
    assign trial_ge = (trial >= {1'b0, d_reg});

    // Truncated signed results: quotient sign from both operands, remainder from dividend
    assign quo_s = neg_q_reg ? -$signed(q_reg) : $signed(q_reg);
    assign rmd_s = neg_r_reg ? -$signed(rem_reg) : $signed(rem_reg);

    assign eq_sum = EW'(num_a) + EW'(num_b);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        mstep_next     = mstep_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        na_next        = na_reg;
        da_next        = da_reg;
        nb_next        = nb_reg;
        db_next        = db_reg;
        prod_next      = prod_reg;
        sn_next        = sn_reg;
        sd_next        = sd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rn_next        = rn_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        d_next         = d_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        err_next       = err_reg;
        sum_num_next   = sum_num_reg;
        sum_den_next   = sum_den_reg;
        red_num_next   = red_num_reg;
        red_den_next   = red_den_reg;
        zde_next       = zde_reg;

        // Drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    na_next   = num_a;
                    da_next   = den_a;
                    nb_next   = num_b;
                    db_next   = den_b;
                    kind_next = DK_EUCLID;
                    if ((den_a == '0) || (den_b == '0))
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (den_a == den_b)
                    begin
                        err_next   = 1'b0;
                        sn_next    = eq_sum;
                        sd_next    = EW'(den_a);
                        a_next     = eq_sum;
                        b_next     = EW'(den_a);
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        mstep_next = 2'd0;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                // Cross products through the one multiplier, accumulate a step later
                prod_next  = mul_p;
                mstep_next = mstep_reg + 2'd1;
                case (mstep_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        sn_next = EW'(prod_reg);
                    end
                    2'd2:
                    begin
                        sn_next = sn_reg + EW'(prod_reg);
                    end
                    default:
                    begin
                        sd_next    = EW'(prod_reg);
                        a_next     = sn_reg;
                        b_next     = EW'(prod_reg);
                        state_next = ST_LOAD;
                    end
                endcase
            end

            ST_LOAD:
            begin
                // Take magnitudes and remember the signs for the fix-up
                q_next     = dvd[EW-1] ? EW'(-dvd) : EW'(dvd);
                d_next     = b_reg[EW-1] ? EW'(-b_reg) : EW'(b_reg);
                rem_next   = '0;
                neg_q_next = dvd[EW-1] ^ b_reg[EW-1];
                neg_r_next = dvd[EW-1];
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                rem_next = trial_ge ? EW'(trial - {1'b0, d_reg}) : EW'(trial);
                q_next   = {q_reg[EW-2:0], trial_ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(EW - 1))
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                case (kind_reg)
                    DK_EUCLID:
                    begin
                        // Advance Euclid while the remainder is nonzero
                        if (rmd_s != '0)
                        begin
                            a_next = b_reg;
                            b_next = rmd_s;
                        end
                        else
                        begin
                            kind_next = DK_QNUM;
                        end
                        state_next = ST_LOAD;
                    end
                    DK_QNUM:
                    begin
                        rn_next    = quo_s;
                        kind_next  = DK_QDEN;
                        state_next = ST_LOAD;
                    end
                    default:
                    begin
                        // Keep the reduced denominator in b, the divisor is no longer needed
                        b_next     = quo_s;
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_FIN:
            begin
                // Hold until the output register is free, then load the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    zde_next       = err_reg;
                    if (err_reg)
                    begin
                        sum_num_next = '0;
                        sum_den_next = '0;
                        red_num_next = '0;
                        red_den_next = '0;
                    end
                    else
                    begin
                        sum_num_next = NUM_W'(sn_reg);
                        sum_den_next = DEN_W'(sd_reg);
                        red_num_next = NUM_W'(rn_reg);
                        red_den_next = DEN_W'(b_reg);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= DK_EUCLID;
            mstep_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            mstep_reg     <= mstep_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        na_reg      <= na_next;
        da_reg      <= da_next;
        nb_reg      <= nb_next;
        db_reg      <= db_next;
        prod_reg    <= prod_next;
        sn_reg      <= sn_next;
        sd_reg      <= sd_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        rn_reg      <= rn_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        neg_q_reg   <= neg_q_next;
        neg_r_reg   <= neg_r_next;
        err_reg     <= err_next;
        sum_num_reg <= sum_num_next;
        sum_den_reg <= sum_den_next;
        red_num_reg <= red_num_next;
        red_den_reg <= red_den_next;
        zde_reg     <= zde_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign sum_num        = sum_num_reg;
    assign sum_den        = sum_den_reg;
    assign red_num        = red_num_reg;
    assign red_den        = red_den_reg;
    assign zero_den_error = zde_reg;

    // Divider never runs with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (d_reg != '0))
    else $error("divider started with zero divisor");

    // Block is busy right after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
    else $error("input accepted while busy");

    // Error results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_den_error) |->
            (sum_num == '0 && sum_den == '0 && red_num == '0 && red_den == '0))
    else $error("zero denominator result not cleared");

    // Bit counter stays within the divider width
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CW'(EW)))
    else $error("divider bit counter overrun");

    // A finished result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
    else $error("pending result lost");

endmodule : fraction_add_and_reduce_core

`default_nettype wire
